// File: rtl/core/tbbs_pkg.sv
// shared constants for the two-button brightness stepper
// event latch codes, mode limits and the mode-to-duty table
// no dependencies
package tbbs_pkg;

  localparam int unsigned HoldW  = 8;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned EventW = 2;

  // one-deep event latch codes
  localparam logic [EventW-1:0] EV_FREE  = 2'd0;
  localparam logic [EventW-1:0] EV_CLICK = 2'd1;
  localparam logic [EventW-1:0] EV_LONG  = 2'd2;

  // brightness modes that the step rules name
  localparam logic [ModeW-1:0] MODE_OFF      = 3'd0;
  localparam logic [ModeW-1:0] MODE_LOWEST   = 3'd1;
  localparam logic [ModeW-1:0] MODE_LONG_DN  = 3'd3;
  localparam logic [ModeW-1:0] MODE_LONG_UP  = 3'd4;
  localparam logic [ModeW-1:0] MODE_TOP_STEP = 3'd5;
  localparam logic [ModeW-1:0] MODE_TURBO    = 3'd6;

  // configuration register indexes
  localparam logic REG_CLICK_TICKS = 1'b0;
  localparam logic REG_LONG_TICKS  = 1'b1;

  localparam logic [HoldW-1:0] CLICK_TICKS_RST = 8'd5;
  localparam logic [HoldW-1:0] LONG_TICKS_RST  = 8'd100;

  // packed result word
  localparam int unsigned OutDataW = 16;

  typedef struct packed {
    logic [HoldW-1:0]  hold;
    logic              locked;
    logic [EventW-1:0] event_code;
  } button_t;

  function automatic logic [DutyW-1:0] mode_duty(input logic [ModeW-1:0] mode);
    logic [DutyW-1:0] duty;
    unique case (mode)
      3'd1:    duty = 8'd10;
      3'd2:    duty = 8'd15;
      3'd3:    duty = 8'd31;
      3'd4:    duty = 8'd63;
      3'd5:    duty = 8'd127;
      3'd6:    duty = 8'd255;
      default: duty = 8'd0;
    endcase
    return duty;
  endfunction

endpackage

// File: rtl/core/two_button_brightness_stepper.sv
// two-button brightness stepper: hold counters, event latches and mode step
// depends on tbbs_pkg
//
// usage
//   input stream: one request per cycle; tuser selects the kind of request,
//   0 samples both button levels, 1 runs a mode step that consumes the latched
//   events. tdata carries the button levels.
//   output stream: exactly one result per request, carrying the brightness
//   mode after the request, its pwm duty, the driver enable and, for a step,
//   whether a click or a long press was consumed.
//   apb port: click_ticks at byte address 0, long_ticks at address 4; the user
//   writes them only while the block is idle, unenforced. pready is tied high.
// latency and throughput
//   a result appears in the cycle after its request is accepted; one request
//   per cycle is sustained while results are taken. the rate is set by the
//   state update, which is a single pass of logic in front of the output register.
// reset
//   hold counters, lock bits, event latches and mode clear, registers return
//   to 5 and 100, the output register empties.
// stall
//   while the receiver holds tready low, the result waits in the output
//   register and the input side accepts nothing until it is taken.
module two_button_brightness_stepper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] minus_pressed, [1] plus_pressed, rest zero
  input  logic        s_axis_tuser_i,   // [0] op
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [2:0] mode, [10:3] pwm_duty, [11] driver_enable,
                                        // [12] click_seen, [13] long_seen, rest zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned HoldW = tbbs_pkg::HoldW;
  localparam int unsigned ModeW = tbbs_pkg::ModeW;
  localparam int unsigned DutyW = tbbs_pkg::DutyW;

  // configuration registers
  logic [HoldW-1:0] click_ticks_q;
  logic [HoldW-1:0] long_ticks_q;

  // button and mode state
  tbbs_pkg::button_t minus_q, minus_d;
  tbbs_pkg::button_t plus_q, plus_d;
  logic [ModeW-1:0]  mode_q, mode_d;

  // output register
  logic                              out_valid_q;
  logic [tbbs_pkg::OutDataW-1:0]     out_data_q, out_data_d;

  logic in_accept;
  logic cfg_write;
  logic click_seen, long_seen;
  logic [DutyW-1:0] duty;

  assign pready          = 1'b1;
  assign cfg_write       = psel & penable & pwrite;
  // output register frees up when its result is taken in the same cycle
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;

  // apb read, register picked by address bit 2, misaligned reads give zero
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == tbbs_pkg::REG_CLICK_TICKS) begin
        prdata[HoldW-1:0] = click_ticks_q;
      end else begin
        prdata[HoldW-1:0] = long_ticks_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_ticks_q <= tbbs_pkg::CLICK_TICKS_RST;
      long_ticks_q  <= tbbs_pkg::LONG_TICKS_RST;
    end else if (cfg_write) begin
      if (paddr[2] == tbbs_pkg::REG_CLICK_TICKS) begin
        click_ticks_q <= pwdata[HoldW-1:0];
      end else begin
        long_ticks_q <= pwdata[HoldW-1:0];
      end
    end
  end

  // one sample of one button; a busy latch freezes the button
  function automatic tbbs_pkg::button_t sample_button(
    input tbbs_pkg::button_t cur,
    input logic              pressed,
    input logic [HoldW-1:0]  click_ticks,
    input logic [HoldW-1:0]  long_ticks
  );
    tbbs_pkg::button_t nxt;
    nxt = cur;
    if (cur.event_code == tbbs_pkg::EV_FREE) begin
      if (pressed) begin
        if (!cur.locked) begin
          if (cur.hold == long_ticks) begin
            nxt.event_code = tbbs_pkg::EV_LONG;
            nxt.locked     = 1'b1;
          end else begin
            nxt.hold = cur.hold + HoldW'(1);
          end
        end
      end else begin
        if (!cur.locked && (cur.hold >= click_ticks)) begin
          nxt.event_code = tbbs_pkg::EV_CLICK;
        end
        nxt.hold   = '0;
        nxt.locked = 1'b0;
      end
    end
    return nxt;
  endfunction

  // next state for one request
  always_comb begin
    logic m_long, p_long, m_click, p_click, any_long;
    logic can_up, can_down;
    logic [ModeW-1:0] m;

    minus_d    = minus_q;
    plus_d     = plus_q;
    mode_d     = mode_q;
    click_seen = 1'b0;
    long_seen  = 1'b0;

    m_long   = (minus_q.event_code == tbbs_pkg::EV_LONG);
    p_long   = (plus_q.event_code == tbbs_pkg::EV_LONG);
    m_click  = (minus_q.event_code == tbbs_pkg::EV_CLICK);
    p_click  = (plus_q.event_code == tbbs_pkg::EV_CLICK);
    any_long = m_long | p_long;
    can_up   = (mode_q >= tbbs_pkg::MODE_LOWEST) && (mode_q <= tbbs_pkg::MODE_TOP_STEP);
    can_down = (mode_q > tbbs_pkg::MODE_LOWEST) && (mode_q <= tbbs_pkg::MODE_TURBO);
    m        = mode_q;

    if (!s_axis_tuser_i) begin
      minus_d = sample_button(minus_q, s_axis_tdata_i[0], click_ticks_q, long_ticks_q);
      plus_d  = sample_button(plus_q, s_axis_tdata_i[1], click_ticks_q, long_ticks_q);
    end else begin
      minus_d.event_code = tbbs_pkg::EV_FREE;
      plus_d.event_code  = tbbs_pkg::EV_FREE;
      click_seen         = m_click | p_click;
      long_seen          = any_long;
      if (mode_q == tbbs_pkg::MODE_OFF) begin
        // from off only a long press turns the light on, clicks are ignored
        if (m_long) begin
          m = tbbs_pkg::MODE_LONG_DN;
        end else if (p_long) begin
          m = tbbs_pkg::MODE_LONG_UP;
        end
      end else if (mode_q <= tbbs_pkg::MODE_TURBO) begin
        // long goes off first, then clicks apply; minus needs a stored mode above lowest and stops at off
        if (any_long) begin
          m = tbbs_pkg::MODE_OFF;
        end
        if (can_up && p_click) begin
          m = m + ModeW'(1);
        end
        if (can_down && m_click && (m != tbbs_pkg::MODE_OFF)) begin
          m = m - ModeW'(1);
        end
      end
      mode_d = m;
    end
  end

  assign duty = tbbs_pkg::mode_duty(mode_d);

  always_comb begin
    out_data_d        = '0;
    out_data_d[2:0]   = mode_d;
    out_data_d[10:3]  = duty;
    out_data_d[11]    = (duty != '0);
    out_data_d[12]    = click_seen;
    out_data_d[13]    = long_seen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minus_q     <= '0;
      plus_q      <= '0;
      mode_q      <= tbbs_pkg::MODE_OFF;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        minus_q     <= minus_d;
        plus_q      <= plus_d;
        mode_q      <= mode_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // every accepted request leaves a result in the output register
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> m_axis_tvalid_o)
    else $error("accepted request left no result");

  // a step request empties both event latches
  a_step_clears_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser_i) |=>
      (minus_q.event_code == tbbs_pkg::EV_FREE) && (plus_q.event_code == tbbs_pkg::EV_FREE))
    else $error("step left an event latched");

  // a sample request never reports consumed events
  a_sample_no_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !s_axis_tuser_i) |=> (m_axis_tdata_o[13:12] == 2'b00))
    else $error("sample result reports consumed events");

  // mode stays within the defined range
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= tbbs_pkg::MODE_TURBO)
    else $error("brightness mode out of range");

  // result mode matches the state that produced it
  a_result_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (m_axis_tdata_o[2:0] == mode_q) &&
      (m_axis_tdata_o[11] == (mode_q != tbbs_pkg::MODE_OFF)))
    else $error("result mode disagrees with stored mode");
`endif

endmodule

// File: test/tb_two_button_brightness_stepper.sv
// testbench for the two-button brightness stepper: directed and random request streams
// against a cycle-free predictor of hold counters, event latches and the mode step
// depends on tbbs_pkg and rtl/core/two_button_brightness_stepper.sv

// request kinds carried in tuser
localparam logic OP_SAMPLE = 1'b0;
localparam logic OP_STEP   = 1'b1;

typedef struct packed {
  logic [tbbs_pkg::ModeW-1:0] mode;
  logic [tbbs_pkg::DutyW-1:0] duty;
  logic                       driver_on;
  logic                       click_seen;
  logic                       long_seen;
} stepper_out_t;

class brightness_checker;
  tbbs_pkg::button_t          minus_btn;
  tbbs_pkg::button_t          plus_btn;
  logic [tbbs_pkg::ModeW-1:0] mode;
  logic [tbbs_pkg::HoldW-1:0] click_ticks;
  logic [tbbs_pkg::HoldW-1:0] long_ticks;
  stepper_out_t               outputs_due[$];
  int                         errors;

  function new();
    minus_btn   = '0;
    plus_btn    = '0;
    mode        = tbbs_pkg::MODE_OFF;
    click_ticks = tbbs_pkg::CLICK_TICKS_RST;
    long_ticks  = tbbs_pkg::LONG_TICKS_RST;
    errors      = 0;
  endfunction

  function void write_config(logic idx, logic [tbbs_pkg::HoldW-1:0] value);
    case (idx)
      tbbs_pkg::REG_CLICK_TICKS: click_ticks = value;
      tbbs_pkg::REG_LONG_TICKS:  long_ticks  = value;
    endcase
  endfunction

  function int pending();
    return outputs_due.size();
  endfunction

  // one sample of one button, skipped while its latch is full
  function tbbs_pkg::button_t sampled(tbbs_pkg::button_t b, logic pressed);
    tbbs_pkg::button_t nb;
    nb = b;
    if (b.event_code != tbbs_pkg::EV_FREE) return b;
    if (pressed) begin
      if (b.locked) return b;
      if (b.hold == long_ticks) begin
        nb.event_code = tbbs_pkg::EV_LONG;
        nb.locked     = 1'b1;
      end else begin
        nb.hold = b.hold + 8'd1;
      end
    end else begin
      if (!b.locked && b.hold >= click_ticks) nb.event_code = tbbs_pkg::EV_CLICK;
      nb.hold   = '0;
      nb.locked = 1'b0;
    end
    return nb;
  endfunction

  function logic [tbbs_pkg::DutyW-1:0] duty_for(logic [tbbs_pkg::ModeW-1:0] m);
    case (m)
      3'd1:    return 8'd10;
      3'd2:    return 8'd15;
      3'd3:    return 8'd31;
      3'd4:    return 8'd63;
      3'd5:    return 8'd127;
      3'd6:    return 8'd255;
      default: return 8'd0;
    endcase
  endfunction

  function void note_request(logic op, logic mp, logic pp);
    stepper_out_t                o;
    logic [tbbs_pkg::EventW-1:0] m_ev;
    logic [tbbs_pkg::EventW-1:0] p_ev;
    logic                        any_long;
    logic                        m_click;
    logic                        p_click;
    logic                        can_up;
    logic                        can_down;
    logic [tbbs_pkg::ModeW-1:0]  nm;
    o = '0;
    if (op == OP_SAMPLE) begin
      minus_btn = sampled(minus_btn, mp);
      plus_btn  = sampled(plus_btn, pp);
    end else begin
      m_ev     = minus_btn.event_code;
      p_ev     = plus_btn.event_code;
      any_long = (m_ev == tbbs_pkg::EV_LONG) || (p_ev == tbbs_pkg::EV_LONG);
      m_click  = (m_ev == tbbs_pkg::EV_CLICK);
      p_click  = (p_ev == tbbs_pkg::EV_CLICK);
      minus_btn.event_code = tbbs_pkg::EV_FREE;
      plus_btn.event_code  = tbbs_pkg::EV_FREE;
      o.click_seen = m_click || p_click;
      o.long_seen  = any_long;
      if (mode == tbbs_pkg::MODE_OFF) begin
        if (m_ev == tbbs_pkg::EV_LONG) mode = tbbs_pkg::MODE_LONG_DN;
        else if (p_ev == tbbs_pkg::EV_LONG) mode = tbbs_pkg::MODE_LONG_UP;
      end else if (mode <= tbbs_pkg::MODE_TURBO) begin
        can_up   = (mode <= tbbs_pkg::MODE_TOP_STEP);
        can_down = (mode > tbbs_pkg::MODE_LOWEST);
        nm = mode;
        if (any_long) nm = tbbs_pkg::MODE_OFF;
        if (can_up && p_click) nm = nm + 3'd1;
        if (can_down && m_click && nm != tbbs_pkg::MODE_OFF) nm = nm - 3'd1;
        mode = nm;
      end
    end
    o.mode      = mode;
    o.duty      = duty_for(mode);
    o.driver_on = (o.duty != '0);
    outputs_due.push_back(o);
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch on %s, got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  task check_result(logic [15:0] d);
    stepper_out_t w;
    if (outputs_due.size() == 0) begin
      report("result with nothing due", d, '0);
      return;
    end
    w = outputs_due.pop_front();
    if (d[2:0] !== w.mode)       report("mode", 16'(d[2:0]), 16'(w.mode));
    if (d[10:3] !== w.duty)      report("pwm_duty", 16'(d[10:3]), 16'(w.duty));
    if (d[11] !== w.driver_on)   report("driver_enable", 16'(d[11]), 16'(w.driver_on));
    if (d[12] !== w.click_seen)  report("click_seen", 16'(d[12]), 16'(w.click_seen));
    if (d[13] !== w.long_seen)   report("long_seen", 16'(d[13]), 16'(w.long_seen));
    if (d[15:14] !== 2'b00)      report("tdata padding", 16'(d[15:14]), '0);
  endtask
endclass

module tb_two_button_brightness_stepper;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  // request side
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data  = '0;   // [0] minus_pressed, [1] plus_pressed
  logic        s_user  = OP_SAMPLE;   // [0] op
  // result side
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;   // [2:0] mode, [10:3] duty, [11] enable, [12] click, [13] long
  // apb
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  brightness_checker sb = new();

  // thresholds the random gestures are shaped around
  int unsigned cur_click = tbbs_pkg::CLICK_TICKS_RST;
  int unsigned cur_long  = tbbs_pkg::LONG_TICKS_RST;
  int unsigned sent_count = 0;
  // both sides stop idling while set
  bit          no_idle = 1'b0;
  // receiver hold-off, counted down by the receiver itself
  int          rx_hold_left = 0;

  two_button_brightness_stepper DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: check every accepted result, then pick next tready
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_valid && m_ready) sb.check_result(m_data);
      if (rx_hold_left > 0) begin
        m_ready <= 1'b0;
        rx_hold_left--;
      end else if (no_idle) begin
        m_ready <= 1'b1;
      end else begin
        m_ready <= ($urandom_range(99) >= 31);
      end
    end
  end

  // one request, with random idle cycles in front; valid stays high on return
  task automatic send_request(logic op, logic mp, logic pp);
    while (!no_idle && $urandom_range(99) < 31) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {6'b0, pp, mp};
    do @(posedge clk_i); while (!s_ready);
    sb.note_request(op, mp, pp);
    sent_count++;
  endtask

  // n sample requests with fixed button levels
  task automatic hold_buttons(logic mp, logic pp, int n);
    repeat (n) send_request(OP_SAMPLE, mp, pp);
  endtask

  task automatic do_step();
    send_request(OP_STEP, 1'b0, 1'b0);
  endtask

  // sender pauses until every expected result is back
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready, then back to idle
  task automatic write_reg(logic idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_config(idx, value);
    @(posedge clk_i);
  endtask

  // new thresholds only once the block is idle
  task automatic set_thresholds(int unsigned ck, int unsigned lt);
    wait_drained();
    repeat (3) @(posedge clk_i);
    write_reg(tbbs_pkg::REG_CLICK_TICKS, ck[7:0]);
    write_reg(tbbs_pkg::REG_LONG_TICKS, lt[7:0]);
    cur_click = ck;
    cur_long  = lt;
  endtask

  // press length: too short for a click, a click, or a long press
  function automatic int press_len();
    case ($urandom_range(0, 2))
      0:       return (cur_click == 0) ? 0 : $urandom_range(cur_click - 1, 0);
      1:       return $urandom_range(cur_click, cur_long);
      default: return cur_long + 1 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic run_gesture();
    int       kind;
    int       n;
    logic [1:0] which;
    kind  = $urandom_range(0, 9);
    which = 2'($urandom_range(1, 3));
    n     = press_len();
    if (kind <= 5) begin
      // well-formed: press, release, step
      hold_buttons(which[0], which[1], n);
      hold_buttons(1'b0, 1'b0, $urandom_range(1, 2));
      do_step();
    end else if (kind <= 7) begin
      // noise
      repeat ($urandom_range(1, 8)) begin
        send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end
    end else if (kind == 8) begin
      do_step();
    end else begin
      // broken: step while still held, then keep holding and release
      hold_buttons(which[0], which[1], n);
      do_step();
      hold_buttons(which[0], which[1], $urandom_range(0, 3));
      hold_buttons(1'b0, 1'b0, 1);
    end
  endtask

  task automatic run_phase(int unsigned budget);
    int unsigned stop_at;
    stop_at = sent_count + budget;
    while (sent_count < stop_at) run_gesture();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, zero thresholds
    set_thresholds(0, 0);
    do_step();                       // off with nothing latched
    hold_buttons(1'b0, 1'b0, 1);     // zero click ticks: release latches click on both
    hold_buttons(1'b1, 1'b1, 1);     // latches full: sample leaves buttons alone
    do_step();                       // off ignores clicks
    hold_buttons(1'b1, 1'b1, 1);     // zero long ticks: first press latches long on both
    do_step();                       // minus long takes precedence: mode 3
    hold_buttons(1'b1, 1'b1, 1);     // locked, nothing counts
    hold_buttons(1'b0, 1'b0, 1);     // locked release: no click
    hold_buttons(1'b0, 1'b0, 1);     // unlocked release: clicks on both
    do_step();                       // both clicks cancel

    // directed part, small thresholds
    set_thresholds(1, 2);
    repeat (3) begin                 // plus clicks up to turbo
      hold_buttons(1'b0, 1'b1, 1);
      hold_buttons(1'b0, 1'b0, 1);
      do_step();
    end
    hold_buttons(1'b1, 1'b0, 2);     // minus click steps down from turbo
    hold_buttons(1'b0, 1'b0, 1);
    do_step();
    hold_buttons(1'b1, 1'b0, 1);     // minus click plus a plus long: saturates at off
    hold_buttons(1'b0, 1'b0, 1);
    hold_buttons(1'b0, 1'b1, 3);
    do_step();

    // random phases across thresholds, the extremes among them
    set_thresholds(tbbs_pkg::CLICK_TICKS_RST, tbbs_pkg::LONG_TICKS_RST);
    run_phase(300);
    set_thresholds(254, 254);
    run_phase(400);
    set_thresholds(0, 1);
    no_idle = 1'b1;
    run_phase(250);
    no_idle = 1'b0;
    set_thresholds(2, 6);
    rx_hold_left = 150;              // long receiver stall while requests keep coming
    run_phase(300);
    set_thresholds(3, 12);
    run_phase(300);

    // hold counter above a lowered long threshold wraps around
    set_thresholds(5, 200);
    hold_buttons(1'b1, 1'b0, 10);
    set_thresholds(5, 3);
    hold_buttons(1'b1, 1'b0, 250);
    hold_buttons(1'b0, 1'b0, 1);
    do_step();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
